@@ src/naive_substring_search_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the substring search core
// Immediate-implication and next-cycle-implication checks, clocked on clk and
// held off while arst_n is low. Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef NAIVE_SUBSTRING_SEARCH_CORE_ASSERT_SVH
`define NAIVE_SUBSTRING_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define NSS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define NSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define NSS_ASSERT_IMPL(lbl, ante, cons)
`define NSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/nss_pkg.sv @@
// ----------------------------------------------------------------------------
// nss_pkg
// Shared types, command codes and defaults for the substring search core.
// ----------------------------------------------------------------------------
package nss_pkg;

	localparam int MAX_LEN_DEF = 256;

	localparam logic [1:0] CMD_TEXT   = 2'd0;
	localparam logic [1:0] CMD_PAT    = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] ch;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [7:0] position;
		logic       overflowed;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic app_text;
		logic app_pat;
		logic start;
		logic step;
		logic finish;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic loop_go;
	} dp_stat_t;

endpackage

@@ src/nss_ram.sv @@
// ----------------------------------------------------------------------------
// nss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/nss_ctrl.sv @@
// ----------------------------------------------------------------------------
// nss_ctrl
// Sequencer for the search: handshakes, compare loop and result valid.
// ----------------------------------------------------------------------------
module nss_ctrl
	import nss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic [1:0] req_cmd,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TEST = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;

	logic [1:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       acc;

	// a new search waits until the previous result beat has gone
	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && (req_cmd == CMD_SEARCH));
	assign acc       = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.app_text = acc && (req_cmd == CMD_TEXT);
		cmd.app_pat  = acc && (req_cmd == CMD_PAT);
		unique case (state_q)
			ST_IDLE: begin
				if (acc && (req_cmd == CMD_SEARCH)) begin
					cmd.start = 1'b1;
					state_d   = ST_TEST;
				end
			end
			ST_TEST: begin
				if (stat.loop_go) begin
					state_d = ST_CMP;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_CMP: begin
				cmd.step = 1'b1;
				state_d  = ST_TEST;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/nss_dp.sv @@
// ----------------------------------------------------------------------------
// nss_dp
// Buffers, fill counts, match indices and result register.
// ----------------------------------------------------------------------------
module nss_dp
	import nss_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_cmd_t   cmd,
	input  logic [7:0] ch,
	output dp_stat_t   stat,
	output rsp_t       rsp
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

	logic [CW-1:0] tc_q, pc_q, i_q, j_q;
	logic          ovf_q;
	rsp_t          rsp_q;
	logic [7:0]    t_rd, p_rd;
	logic          t_we, p_we, hit;

	assign t_we = cmd.app_text && (tc_q != FULL);
	assign p_we = cmd.app_pat && (pc_q != FULL);
	assign hit  = (j_q >= pc_q);

	assign stat.loop_go = (i_q < tc_q) && (j_q < pc_q);
	assign rsp          = rsp_q;

	nss_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (tc_q[AW-1:0]),
		.wdata (ch),
		.raddr (i_q[AW-1:0]),
		.rdata (t_rd)
	);

	nss_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pat_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (pc_q[AW-1:0]),
		.wdata (ch),
		.raddr (j_q[AW-1:0]),
		.rdata (p_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q  <= '0;
			pc_q  <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.finish) begin
			tc_q  <= '0;
			pc_q  <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (t_we) begin
				tc_q <= tc_q + CW'(1);
			end
			if (p_we) begin
				pc_q <= pc_q + CW'(1);
			end
			if ((cmd.app_text && !t_we) || (cmd.app_pat && !p_we)) begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.step) begin
			if (t_rd == p_rd) begin
				i_q <= i_q + CW'(1);
				j_q <= j_q + CW'(1);
			end else begin
				// back up to one past where this attempt began
				i_q <= i_q - j_q + CW'(1);
				j_q <= '0;
			end
		end
		if (cmd.finish) begin
			rsp_q.found      <= hit;
			rsp_q.position   <= hit ? 8'(i_q - pc_q) : 8'd0;
			rsp_q.overflowed <= ovf_q;
		end
	end

endmodule

@@ src/naive_substring_search_core.sv @@
// ----------------------------------------------------------------------------
// naive_substring_search_core
// Brute-force substring search over loaded text and pattern buffers.
// ----------------------------------------------------------------------------
// Load beats (text or pattern byte) are accepted back to back while no search
// is running; a byte arriving at a full buffer is dropped and flagged. A
// search beat starts the compare loop and holds req_stall high until it ends:
// each compare passes through the test state, which addresses the buffer
// RAMs, and then the compare state, which compares the registered read data.
// The backtracking walk makes at most about text length times pattern length
// byte compares, and the single read port of each buffer RAM sets the pace
// of each one. The result beat is then held in an output register; further
// load beats are taken while it waits, a new search is not. Both strings and
// the overflow flag are cleared when the result is formed, the strings by
// clearing the fill counts, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module naive_substring_search_core
	import nss_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;

	// sequencer: handshakes and loop control
	nss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (dp_stat),
		.cmd       (ctl_cmd)
	);

	// buffers, counters and result register
	nss_dp #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ctl_cmd),
		.ch     (req.ch),
		.stat   (dp_stat),
		.rsp    (rsp)
	);

`include "naive_substring_search_core_assert.svh"

	// at most one datapath command per cycle
	`NSS_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(ctl_cmd))
	// the end of the loop always presents a result beat
	`NSS_ASSERT_NEXT(a_finish_rsp, ctl_cmd.finish, rsp_valid)
	// a search never starts while an earlier result is still waiting
	`NSS_ASSERT_IMPL(a_start_free, ctl_cmd.start, !rsp_valid)

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the brute-force substring search core. Text and
// pattern bytes are streamed in beat by beat and each search result is
// compared with a local model of the buffers and the backtracking walk.
// ----------------------------------------------------------------------------
module tb_top;
	import nss_pkg::*;

	localparam int         CAPACITY     = MAX_LEN_DEF;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT  = 1_000_000;
	localparam int         TAIL_CYCLES  = 64;
	localparam int         RANDOM_BEATS = 100;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	naive_substring_search_core #(
		.MAX_LEN(CAPACITY)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Local copy of the block's buffers, fill counts and drop flag
	// ------------------------------------------------------------------------
	logic [7:0] text_bytes [CAPACITY];
	logic [7:0] pat_bytes  [CAPACITY];
	int         text_fill     = 0;
	int         pat_fill      = 0;
	bit         bytes_dropped = 1'b0;
	rsp_t       awaited_matches [$];

	// bookkeeping
	int error_count     = 0;
	int load_beats      = 0;
	int matches_checked = 0;
	int stalled_cycles  = 0;
	int cycle_count     = 0;

	// sender burst control and receiver hold-off
	int         burst_left    = 0;
	bit         steady_sender = 1'b0;
	int         hold_request  = 0;
	int         hold_left     = 0;
	logic [7:0] stall_phase   = '0;

	// byte pool for the random strings; a small pool makes matches likely
	logic [7:0] alphabet [3];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns  MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Walk the loaded text with backtracking: on a miss, restart one byte
	// after where the current attempt began and rewind the pattern.
	function automatic rsp_t search_loaded();
		rsp_t        res;
		int          ti;
		int          pi;
		int unsigned at;
		ti = 0;
		pi = 0;
		while (ti < text_fill && pi < pat_fill) begin
			if (text_bytes[ti] == pat_bytes[pi]) begin
				ti++;
				pi++;
			end else begin
				ti = ti - pi + 1;
				pi = 0;
			end
		end
		res.found      = (pi >= pat_fill);
		at             = res.found ? ti - pat_fill : 0;
		res.position   = at[7:0];
		res.overflowed = bytes_dropped;
		return res;
	endfunction

	// Apply one accepted beat to the local buffers; a search queues its
	// expected result and then clears both strings and the drop flag.
	function automatic void track_beat(input req_t beat);
		case (beat.cmd)
			CMD_TEXT: begin
				if (text_fill < CAPACITY) begin
					text_bytes[text_fill] = beat.ch;
					text_fill++;
				end else begin
					bytes_dropped = 1'b1;
				end
			end
			CMD_PAT: begin
				if (pat_fill < CAPACITY) begin
					pat_bytes[pat_fill] = beat.ch;
					pat_fill++;
				end else begin
					bytes_dropped = 1'b1;
				end
			end
			CMD_SEARCH: begin
				awaited_matches.push_back(search_loaded());
				text_fill     = 0;
				pat_fill      = 0;
				bytes_dropped = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Watch both channels at each rising edge. Check the result side first:
	// a result can never belong to a request taken at the same edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_matches.size() == 0) begin
					report_mismatch("result beat with nothing awaited", 32'(rsp), 0);
				end else begin
					want = awaited_matches.pop_front();
					matches_checked++;
					if (rsp.found !== want.found)
						report_mismatch("found", 32'(rsp.found), 32'(want.found));
					if (rsp.position !== want.position)
						report_mismatch("position", 32'(rsp.position),
							32'(want.position));
					if (rsp.overflowed !== want.overflowed)
						report_mismatch("overflowed", 32'(rsp.overflowed),
							32'(want.overflowed));
				end
			end
			if (req_valid && req_stall)
				stalled_cycles++;
			if (req_valid && !req_stall)
				track_beat(req);
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t ns  no progress after %0d cycles", $time, CYCLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: honour a requested long hold-off first, otherwise stall on a
	// rotating pattern - free flow, coin toss, phase divisible by 3, light noise.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			stall_phase <= stall_phase + 8'd1;
			case (stall_phase[7:6])
				2'd0:    rsp_stall <= 1'b0;
				2'd1:    rsp_stall <= ($urandom_range(0, 1) == 1);
				2'd2:    rsp_stall <= (stall_phase % 3 == 0);
				default: rsp_stall <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Sender: offer one beat and hold it until taken. Between bursts drop
	// valid for a random gap, unless the steady mode is on. Valid is left
	// high after the beat is taken; the next call either presents its beat or
	// drops valid for a gap, and a drain lowers it, within the same time step.
	// ------------------------------------------------------------------------
	task automatic send_beat(input logic [1:0] op, input logic [7:0] value);
		req_t beat;
		int   gap;
		beat.cmd = op;
		beat.ch  = value;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (!steady_sender && gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req       <= beat;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (op != CMD_UNUSED && op != CMD_SEARCH)
			load_beats++;
	endtask

	task automatic load_string(input logic [1:0] target, input string s);
		for (int k = 0; k < s.len(); k++)
			send_beat(target, s[k]);
	endtask

	// Drop valid and wait until every queued result has come back. The
	// first edge lets the watcher record a search taken at this very edge.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaited_matches.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Empty strings, over-long pattern, backtracking, and the unused code
	task automatic test_special_cases();
		send_beat(CMD_SEARCH, 8'hFF);          // both empty: match at 0
		load_string(CMD_TEXT, "ab");
		send_beat(CMD_UNUSED, 8'hA5);          // must leave the buffers alone
		send_beat(CMD_SEARCH, 8'h00);          // empty pattern: match at 0
		load_string(CMD_PAT, "a");
		send_beat(CMD_SEARCH, 8'h5A);          // empty text: no match
		load_string(CMD_TEXT, "ab");
		load_string(CMD_PAT, "abc");
		send_beat(CMD_SEARCH, 8'h00);          // pattern longer than text
		load_string(CMD_TEXT, "aaab");
		load_string(CMD_PAT, "aab");
		send_beat(CMD_SEARCH, 8'h00);          // partial match then backtrack
		wait_drained();
	endtask

	// Bytes at both ends of the range, found and not found
	task automatic test_byte_extremes();
		send_beat(CMD_TEXT, 8'h00);
		send_beat(CMD_TEXT, 8'hFF);
		send_beat(CMD_PAT, 8'hFF);
		send_beat(CMD_TEXT, 8'h00);
		send_beat(CMD_PAT, 8'h00);
		send_beat(CMD_SEARCH, 8'h00);
		send_beat(CMD_TEXT, 8'h00);
		send_beat(CMD_PAT, 8'hFF);
		send_beat(CMD_UNUSED, 8'h00);
		send_beat(CMD_SEARCH, 8'hFF);
		wait_drained();
	endtask

	// Full buffers: a match at the last text position with surplus text
	// bytes dropped, then a pattern running past capacity against short text
	task automatic test_buffer_overflow();
		for (int k = 0; k < CAPACITY + 2; k++)
			send_beat(CMD_TEXT, (k == CAPACITY - 1) ? 8'hFF : 8'h00);
		send_beat(CMD_PAT, 8'hFF);
		send_beat(CMD_SEARCH, 8'h00);
		load_string(CMD_TEXT, "zzz");
		for (int k = 0; k < CAPACITY + 1; k++)
			send_beat(CMD_PAT, "z");
		send_beat(CMD_SEARCH, 8'h00);
		wait_drained();
	endtask

	// Hold the receiver off for a long stretch while searches keep coming:
	// the first result parks in the output register and the next search
	// must be stalled at the input until the receiver lets go.
	task automatic test_backpressure();
		string pats [4];
		pats          = '{"hay", "needle", "stack", "q"};
		hold_request  = 400;
		steady_sender = 1'b1;
		for (int n = 0; n < 4; n++) begin
			load_string(CMD_TEXT, "needle in a haystack");
			load_string(CMD_PAT, pats[n]);
			send_beat(CMD_SEARCH, 8'h00);
		end
		steady_sender = 1'b0;
		wait_drained();
	endtask

	function automatic logic [7:0] draw_byte();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return alphabet[$urandom_range(0, 2)];
	endfunction

	// One load-and-search sequence with random content, or now and then a
	// short run of arbitrary beats. Bumps the count of beats issued.
	task automatic run_random_sequence(inout int issued);
		logic [7:0] text_seq [];
		logic [7:0] pat_seq  [];
		int         tlen;
		int         plen;
		int         at;
		int         ti;
		int         pi;
		int         noise;
		for (int k = 0; k < 3; k++)
			alphabet[k] = 8'($urandom_range(0, 255));

		// broken sequence: any command, any byte
		if ($urandom_range(0, 9) == 0) begin
			noise = $urandom_range(1, 8);
			for (int k = 0; k < noise; k++) begin
				at = $urandom_range(0, 3);
				send_beat(at[1:0], 8'($urandom_range(0, 255)));
				if (at[1:0] != CMD_UNUSED)
					issued++;
			end
			return;
		end

		// short strings; the buffer limits are covered by their own test
		tlen = $urandom_range(0, 16);
		plen = $urandom_range(0, 5);
		text_seq = new[tlen];
		pat_seq  = new[plen];
		for (int k = 0; k < plen; k++)
			pat_seq[k] = draw_byte();
		for (int k = 0; k < tlen; k++)
			text_seq[k] = draw_byte();

		// plant the pattern somewhere in the text half of the time
		if (plen > 0 && plen <= tlen && $urandom_range(0, 1) == 1) begin
			at = $urandom_range(0, tlen - plen);
			for (int k = 0; k < plen; k++)
				text_seq[at + k] = pat_seq[k];
		end

		// interleave text and pattern beats, with the odd unused command
		ti = 0;
		pi = 0;
		while (ti < tlen || pi < plen) begin
			if ($urandom_range(0, 15) == 0)
				send_beat(CMD_UNUSED, 8'($urandom_range(0, 255)));
			if (pi == plen || (ti < tlen && $urandom_range(0, 1) == 1)) begin
				send_beat(CMD_TEXT, text_seq[ti]);
				ti++;
			end else begin
				send_beat(CMD_PAT, pat_seq[pi]);
				pi++;
			end
		end
		send_beat(CMD_SEARCH, 8'($urandom_range(0, 255)));
		issued += tlen + plen + 1;
	endtask

	task automatic test_random_traffic();
		int issued;
		issued = 0;
		while (issued < RANDOM_BEATS) begin
			// switch the sender between bursty and gap-free stretches
			steady_sender = ($urandom_range(0, 4) == 0);
			run_random_sequence(issued);
		end
		steady_sender = 1'b0;
		wait_drained();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_byte_extremes();
		test_buffer_overflow();
		test_backpressure();
		test_random_traffic();

		// catch any stray result after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_matches.size() != 0)
			report_mismatch("results never delivered", awaited_matches.size(), 0);

		$display("Checked %0d search results over %0d text and pattern byte beats.",
			matches_checked, load_beats);
		$display("Input held back for %0d cycles; %0d mismatches in %0d cycles.",
			stalled_cycles, error_count, cycle_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
